[hdl/okrl_pkg.sv]
`timescale 1ns / 1ps
// Package for the ordered keyed record list: word types, request and status
// codes, cell operations and controller states. Depends on nothing.
package okrl_pkg;

    localparam int KEY_W            = 31;
    localparam int PAYLOAD_W        = 32;
    localparam int REQ_W            = 3;
    localparam int POS_W            = 4;
    localparam int STATUS_W         = 2;
    localparam int COUNT_OUT_W      = 5;
    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT_HEAD = 3'd0,
        REQ_APPEND_TAIL = 3'd1,
        REQ_SEARCH      = 3'd2,
        REQ_DELETE      = 3'd3,
        REQ_READ        = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_LOAD
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } fsm_t;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic [POS_W-1:0]     position;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [KEY_W-1:0]       found_key;
        logic [PAYLOAD_W-1:0]   found_payload;
        logic [COUNT_OUT_W-1:0] entry_count;
    } out_word_t;

endpackage

[hdl/okrl_cell.sv]
`timescale 1ns / 1ps
// One cell of the record row: holds a key and a payload, compares its key
// with the probe key and takes its neighbour's record on a shift. Uses okrl_pkg.
module okrl_cell
    import okrl_pkg::*;
#(
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic                    clk,
    input  cell_op_t                op,
    input  logic [KEY_W-1:0]        probe_key,
    input  logic [KEY_W-1:0]        prev_key,
    input  logic [PAYLOAD_BITS-1:0] prev_payload,
    input  logic [KEY_W-1:0]        next_key,
    input  logic [PAYLOAD_BITS-1:0] next_payload,
    input  logic [KEY_W-1:0]        load_key,
    input  logic [PAYLOAD_BITS-1:0] load_payload,
    output logic [KEY_W-1:0]        key,
    output logic [PAYLOAD_BITS-1:0] payload,
    output logic                    key_eq
);

    logic [KEY_W-1:0]        key_reg;
    logic [KEY_W-1:0]        key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;

    always_comb
    begin
        unique case (op)
            CELL_FROM_PREV:
            begin
                key_next     = prev_key;
                payload_next = prev_payload;
            end
            CELL_FROM_NEXT:
            begin
                key_next     = next_key;
                payload_next = next_payload;
            end
            CELL_LOAD:
            begin
                key_next     = load_key;
                payload_next = load_payload;
            end
            default:
            begin
                key_next     = key_reg;
                payload_next = payload_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;
    assign key_eq  = (key_reg == probe_key);

endmodule

[hdl/ordered_keyed_record_list.sv]
`timescale 1ns / 1ps
// Top level of the ordered keyed record list: controller, count and output
// register around a row of okrl_cell instances. Uses okrl_pkg and okrl_cell.
//
// The list is a row of DEPTH cells, position 0 at the head; a new request
// is accepted only in the idle state. At the edge that accepts a word every
// cell compares its key with the request key and the match flags are registered;
// in the apply state that follows the first match from the head is picked, the
// row shifts by one cell towards the tail (insert at head) or the head (delete),
// and the result word is loaded into the output register. The apply state waits
// while an earlier result has not been taken. No clearing pass follows reset:
// only positions below the record count are ever read.
module ordered_keyed_record_list
    import okrl_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    fsm_t                    state_reg;
    fsm_t                    state_next;
    in_word_t                req_reg;
    logic [DEPTH-1:0]        match_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    out_valid_reg;
    out_word_t               out_word_reg;
    out_word_t               out_word_next;

    cell_op_t                cell_op [DEPTH];
    logic [KEY_W-1:0]        cell_key [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
    logic [DEPTH-1:0]        key_eq;
    logic [DEPTH-1:0]        match_live;

    logic                    accept;
    logic                    go;
    logic [DEPTH-1:0]        first_hit;
    logic [DEPTH-1:0]        at_or_after;
    logic [DEPTH-1:0]        pos_onehot;
    logic [DEPTH-1:0]        tail_onehot;
    logic [DEPTH-1:0]        sel;
    logic                    hit;
    logic                    full;
    logic                    empty;
    logic                    pos_ok;
    logic                    show;
    status_t                 status;
    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_payload;
    logic [63:0]             new_payload_wide;
    logic [63:0]             rd_payload_wide;
    logic [31:0]             count_wide;
    logic [PAYLOAD_BITS-1:0] new_payload;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign go       = !out_valid_reg || out_ready;

    assign new_payload_wide = 64'(req_reg.payload);
    assign new_payload      = new_payload_wide[PAYLOAD_BITS-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [KEY_W-1:0]        prev_key;
            logic [PAYLOAD_BITS-1:0] prev_payload;
            logic [KEY_W-1:0]        next_key;
            logic [PAYLOAD_BITS-1:0] next_payload;

            if (gi == 0)
            begin : g_head
                assign prev_key     = req_reg.key;
                assign prev_payload = new_payload;
            end
            else
            begin : g_body
                assign prev_key     = cell_key[gi-1];
                assign prev_payload = cell_payload[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign next_key     = cell_key[gi];
                assign next_payload = cell_payload[gi];
            end
            else
            begin : g_inner
                assign next_key     = cell_key[gi+1];
                assign next_payload = cell_payload[gi+1];
            end

            okrl_cell #(
                .PAYLOAD_BITS(PAYLOAD_BITS)
            ) u_cell (
                .clk         (clk),
                .op          (cell_op[gi]),
                .probe_key   (in_word.key),
                .prev_key    (prev_key),
                .prev_payload(prev_payload),
                .next_key    (next_key),
                .next_payload(next_payload),
                .load_key    (req_reg.key),
                .load_payload(new_payload),
                .key         (cell_key[gi]),
                .payload     (cell_payload[gi]),
                .key_eq      (key_eq[gi])
            );

            assign match_live[gi] = key_eq[gi] && (CNT_W'(gi) < count_reg);
        end
    endgenerate

    assign first_hit   = match_reg & (~match_reg + DEPTH'(1));
    assign at_or_after = ~(first_hit - DEPTH'(1));
    assign hit         = |match_reg;
    assign full        = (count_reg == CNT_W'(DEPTH));
    assign empty       = (count_reg == '0);
    assign pos_onehot  = DEPTH'(1) << req_reg.position;
    assign tail_onehot = DEPTH'(1) << count_reg;
    assign pos_ok      = (32'(req_reg.position) < 32'(count_reg));

    always_comb
    begin
        rd_key     = '0;
        rd_payload = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel[i])
            begin
                rd_key     = rd_key | cell_key[i];
                rd_payload = rd_payload | cell_payload[i];
            end
        end
    end

    assign rd_payload_wide = 64'(rd_payload);
    assign count_wide      = 32'(count_next);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        status     = STAT_NOT_FOUND;
        show       = 1'b0;
        sel        = pos_onehot;
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_op[i] = CELL_HOLD;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                unique case (req_t'(req_reg.req_type)) inside
                    REQ_INSERT_HEAD, REQ_APPEND_TAIL:
                    begin
                        if (full)
                        begin
                            status = STAT_FULL;
                        end
                        else
                        begin
                            status     = STAT_OK;
                            count_next = count_reg + CNT_W'(1);
                            for (int i = 0; i < DEPTH; i++)
                            begin
                                if (req_reg.req_type == REQ_INSERT_HEAD)
                                begin
                                    cell_op[i] = CELL_FROM_PREV;
                                end
                                else if (tail_onehot[i])
                                begin
                                    cell_op[i] = CELL_LOAD;
                                end
                            end
                        end
                    end
                    REQ_SEARCH:
                    begin
                        sel = first_hit;
                        if (hit)
                        begin
                            status = STAT_OK;
                            show   = 1'b1;
                        end
                    end
                    REQ_DELETE:
                    begin
                        sel = first_hit;
                        if (empty)
                        begin
                            status = STAT_EMPTY;
                        end
                        else if (hit)
                        begin
                            status     = STAT_OK;
                            show       = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                            for (int i = 0; i < DEPTH; i++)
                            begin
                                if (at_or_after[i])
                                begin
                                    cell_op[i] = CELL_FROM_NEXT;
                                end
                            end
                        end
                    end
                    REQ_READ:
                    begin
                        if (empty)
                        begin
                            status = STAT_EMPTY;
                        end
                        else if (pos_ok)
                        begin
                            status = STAT_OK;
                            show   = 1'b1;
                        end
                    end
                    default:
                    begin
                        status = STAT_NOT_FOUND;
                    end
                endcase

                if (go)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    count_next = count_reg;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        cell_op[i] = CELL_HOLD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_word_next.status        = status;
        out_word_next.found_key     = show ? rd_key : '0;
        out_word_next.found_payload = show ? rd_payload_wide[PAYLOAD_W-1:0] : '0;
        out_word_next.entry_count   = count_wide[COUNT_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_APPLY && go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= in_word;
            match_reg <= match_live;
        end
        if (state_reg == S_APPLY && go)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("record count exceeds the list depth");

    a_first_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |-> $onehot0(first_hit))
        else $error("more than one first match selected");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == S_APPLY && go) |=> $stable(count_reg))
        else $error("record count changed outside the update cycle");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && go) |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result word not presented after the update cycle");
`endif

endmodule
